@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ sv/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Field widths, command and status codes for the indexed list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  // Default number of entries the store can hold.
  localparam int unsigned CapacityDef = 1024;

  // Field widths.
  localparam int unsigned CmdW  = 3;
  localparam int unsigned PosW  = 11;
  localparam int unsigned DataW = 32;
  localparam int unsigned StW   = 2;
  localparam int unsigned LenW  = 11;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InW  = 48;
  localparam int unsigned OutW = 48;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_READ     = 3'd0;
  localparam logic [CmdW-1:0] CMD_INS_HEAD = 3'd1;
  localparam logic [CmdW-1:0] CMD_INS_TAIL = 3'd2;
  localparam logic [CmdW-1:0] CMD_INS_AT   = 3'd3;
  localparam logic [CmdW-1:0] CMD_DELETE   = 3'd4;

  // Status codes.
  localparam logic [StW-1:0] ST_DONE  = 2'd0;
  localparam logic [StW-1:0] ST_RANGE = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ sv/indexed_list_store.sv @@
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed 32-bit values kept packed in a single-port-write,
// single-port-read memory, with read, insert and delete by position.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the slave stream (s_axis_*) and each produces exactly one
// result on the master stream (m_axis_*). A command is taken only when the
// block is idle and its result register is free or being emptied, so one
// command is in flight at a time.
// Steps, counted from the accepting edge to the result appearing:
//   read in range            registered memory read, then the result register
//   reject, tail insert,
//   delete of the last entry result register set on acceptance
//   shifting insert          shift of the entries moved up, then the new value write
//   shifting delete          shift of the entries moved down by one
// The shift walks the memory one entry a cycle, overlapping the read of one
// entry with the write of the one before; that rate is set by the single
// memory write port.
// Reset empties the list at once; memory contents are not cleared and entries
// are only read once written. A stalled receiver holds the result in the
// output register and the block takes no new command until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::CapacityDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Command stream.
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [2:0] command, [13:3] position, [45:14] write_value, [47:46] zero
  input  wire logic [ils_pkg::InW-1:0]   s_axis_tdata,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [31:0] read_value, [33:32] status, [44:34] list_length, [47:45] zero
  output logic [ils_pkg::OutW-1:0]       m_axis_tdata
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > ils_pkg::PosW) ? CntW : ils_pkg::PosW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SHIFT,
    S_WR_VAL
  } state_e;

  // Unpacked command fields.
  logic [ils_pkg::CmdW-1:0]  in_cmd;
  logic [ils_pkg::PosW-1:0]  in_pos;
  logic [ils_pkg::DataW-1:0] in_val;

  assign in_cmd = s_axis_tdata[ils_pkg::CmdW-1:0];
  assign in_pos = s_axis_tdata[ils_pkg::CmdW +: ils_pkg::PosW];
  assign in_val = s_axis_tdata[ils_pkg::CmdW + ils_pkg::PosW +: ils_pkg::DataW];

  // Control and payload registers.
  state_e                    state_q;
  logic [CntW-1:0]           count_q;
  logic [IdxW-1:0]           ptr_q;
  logic [IdxW-1:0]           end_q;
  logic [IdxW-1:0]           pos_q;
  logic [IdxW-1:0]           wa_q;
  logic                      dir_up_q;
  logic                      rd_act_q;
  logic                      wpend_q;
  logic [ils_pkg::DataW-1:0] val_q;
  logic                      out_valid_q;
  logic [ils_pkg::DataW-1:0] out_rd_q;
  logic [ils_pkg::StW-1:0]   out_st_q;
  logic [ils_pkg::LenW-1:0]  out_len_q;

  // Memory ports.
  logic [ils_pkg::DataW-1:0] mem_q [CAPACITY];
  logic [ils_pkg::DataW-1:0] rdata_q;
  logic                      mem_we;
  logic [IdxW-1:0]           mem_wa;
  logic [ils_pkg::DataW-1:0] mem_wd;
  logic                      mem_re;
  logic [IdxW-1:0]           mem_ra;

  logic            in_xfer;
  logic            out_xfer;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] ins_pos;
  logic [CntW-1:0] cnt_inc;
  logic [CntW-1:0] cnt_dec;
  logic            is_full;

  // Handshakes: take a command only when idle and the result slot will be free.
  assign s_axis_tready = (state_q == S_IDLE) && (!out_valid_q || m_axis_tready);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ils_pkg::OutW - ils_pkg::DataW - ils_pkg::StW -
                            ils_pkg::LenW){1'b0}}, out_len_q, out_st_q, out_rd_q};

  // Position arithmetic on a common width.
  assign pos_ext = CmpW'(in_pos);
  assign cnt_ext = CmpW'(count_q);
  assign cnt_inc = count_q + 1'b1;
  assign cnt_dec = count_q - 1'b1;
  assign is_full = (count_q >= CntW'(CAPACITY));

  // Insert position for the three insert commands.
  always_comb begin
    case (in_cmd)
      ils_pkg::CMD_INS_HEAD: ins_pos = '0;
      ils_pkg::CMD_INS_TAIL: ins_pos = cnt_ext;
      default:               ins_pos = pos_ext;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = rdata_q;
    mem_re = 1'b0;
    mem_ra = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            ils_pkg::CMD_READ: begin
              mem_re = (pos_ext < cnt_ext);
              mem_ra = IdxW'(pos_ext);
            end
            ils_pkg::CMD_INS_HEAD, ils_pkg::CMD_INS_TAIL, ils_pkg::CMD_INS_AT: begin
              // Appending at the end needs no shift.
              mem_we = (ins_pos == cnt_ext) && !is_full;
              mem_wa = IdxW'(count_q);
              mem_wd = in_val;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        // Write back the entry read in the previous cycle, read the next one.
        mem_we = wpend_q;
        mem_wa = wa_q;
        mem_re = rd_act_q;
        mem_ra = ptr_q;
      end
      S_WR_VAL: begin
        mem_we = 1'b1;
        mem_wa = pos_q;
        mem_wd = val_q;
      end
      default: begin
      end
    endcase
  end

  // Element memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      pos_q       <= '0;
      wa_q        <= '0;
      dir_up_q    <= 1'b0;
      rd_act_q    <= 1'b0;
      wpend_q     <= 1'b0;
      val_q       <= '0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_st_q    <= ils_pkg::ST_DONE;
      out_len_q   <= '0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            out_rd_q  <= '0;
            out_st_q  <= ils_pkg::ST_DONE;
            out_len_q <= ils_pkg::LenW'(count_q);
            case (in_cmd)
              ils_pkg::CMD_READ: begin
                if (pos_ext < cnt_ext) begin
                  state_q <= S_RD_WAIT;
                end else begin
                  out_st_q    <= ils_pkg::ST_RANGE;
                  out_valid_q <= 1'b1;
                end
              end
              ils_pkg::CMD_INS_HEAD, ils_pkg::CMD_INS_TAIL, ils_pkg::CMD_INS_AT: begin
                if (ins_pos > cnt_ext) begin
                  out_st_q    <= ils_pkg::ST_RANGE;
                  out_valid_q <= 1'b1;
                end else if (is_full) begin
                  out_st_q    <= ils_pkg::ST_FULL;
                  out_valid_q <= 1'b1;
                end else if (ins_pos == cnt_ext) begin
                  count_q     <= cnt_inc;
                  out_len_q   <= ils_pkg::LenW'(cnt_inc);
                  out_valid_q <= 1'b1;
                end else begin
                  // Move entries count-1 down to the insert point up by one.
                  pos_q    <= IdxW'(ins_pos);
                  val_q    <= in_val;
                  ptr_q    <= IdxW'(cnt_dec);
                  end_q    <= IdxW'(ins_pos);
                  dir_up_q <= 1'b0;
                  rd_act_q <= 1'b1;
                  wpend_q  <= 1'b0;
                  state_q  <= S_SHIFT;
                end
              end
              ils_pkg::CMD_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                  out_st_q    <= ils_pkg::ST_RANGE;
                  out_valid_q <= 1'b1;
                end else if (pos_ext == CmpW'(cnt_dec)) begin
                  count_q     <= cnt_dec;
                  out_len_q   <= ils_pkg::LenW'(cnt_dec);
                  out_valid_q <= 1'b1;
                end else begin
                  // Move entries after the deleted one down by one.
                  ptr_q    <= IdxW'(pos_ext) + 1'b1;
                  end_q    <= IdxW'(cnt_dec);
                  dir_up_q <= 1'b1;
                  rd_act_q <= 1'b1;
                  wpend_q  <= 1'b0;
                  state_q  <= S_SHIFT;
                end
              end
              default: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          out_rd_q    <= rdata_q;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        S_SHIFT: begin
          if (rd_act_q) begin
            wa_q    <= dir_up_q ? (ptr_q - 1'b1) : (ptr_q + 1'b1);
            wpend_q <= 1'b1;
            if (ptr_q == end_q) begin
              rd_act_q <= 1'b0;
            end else begin
              ptr_q <= dir_up_q ? (ptr_q + 1'b1) : (ptr_q - 1'b1);
            end
          end else begin
            wpend_q <= 1'b0;
            if (!wpend_q) begin
              if (dir_up_q) begin
                count_q     <= cnt_dec;
                out_len_q   <= ils_pkg::LenW'(cnt_dec);
                out_valid_q <= 1'b1;
                state_q     <= S_IDLE;
              end else begin
                state_q <= S_WR_VAL;
              end
            end
          end
        end
        S_WR_VAL: begin
          count_q     <= cnt_inc;
          out_len_q   <= ils_pkg::LenW'(cnt_inc);
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The length never exceeds the capacity.
  `ASSERT_AT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY))
  // A command transfer either starts a sequence or leaves its result waiting.
  `ASSERT_AT(a_one_in_flight, clk_i, rst_ni, in_xfer |=> (state_q != S_IDLE) || out_valid_q)
  // A full status is only reported when the store really is full.
  `ASSERT_AT(a_full_status, clk_i, rst_ni,
             (out_valid_q && (out_st_q == ils_pkg::ST_FULL)) |-> is_full)
  // The shift never writes beyond the first free slot after the occupied part.
  `ASSERT_NEVER(a_shift_write, clk_i, rst_ni,
                (state_q == S_SHIFT) && mem_we && (CntW'(mem_wa) >= count_q + 1'b1))

endmodule

`default_nettype wire

@@ sim/tb_indexed_list_store.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_list_store
// Self-checking bench for the indexed list store. Commands go in on the slave
// stream and results are checked on the master stream against a queue-based
// prediction of the list. Directed corner cases come first. Random traffic
// follows: a shallow list, a growth phase to a few hundred entries with
// probes of its ends, and random work on that deep list. Both streams idle
// and stall at random.
// ----------------------------------------------------------------------------
module tb_indexed_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap        = ils_pkg::CapacityDef;
  localparam int unsigned HalfPeriod = 1;
  localparam int unsigned ResetLen   = 12;
  // Bound on quiet cycles: covers the longest shift plus the longest gap and stall.
  localparam int unsigned QuietLimit = 20000;
  // Cycles to watch for a stray result after the last expected one.
  localparam int unsigned SettleLen  = Cap + 64;
  localparam int unsigned ShallowLen = 200;
  localparam int unsigned GrowLen    = 240;
  localparam int unsigned DeepLen    = 100;

  // One result as it travels on the master stream, padding excluded.
  typedef struct packed {
    logic [ils_pkg::DataW-1:0] read_value;
    logic [ils_pkg::StW-1:0]   status;
    logic [ils_pkg::LenW-1:0]  list_length;
  } list_result_t;

  // Tracks the list contents and the results still owed by the block.
  class list_scoreboard;
    logic [ils_pkg::DataW-1:0] contents[$];
    list_result_t              pending[$];
    int unsigned               capacity;
    int unsigned               errors;

    function new(int unsigned cap);
      capacity = cap;
      errors   = 0;
    endfunction

    function int unsigned length();
      return contents.size();
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction

    // Shared by all three insert commands; the range check comes first.
    function logic [ils_pkg::StW-1:0] put_entry(int unsigned at,
                                                logic [ils_pkg::DataW-1:0] v);
      if (at > contents.size()) return ils_pkg::ST_RANGE;
      if (contents.size() >= capacity) return ils_pkg::ST_FULL;
      contents.insert(at, v);
      return ils_pkg::ST_DONE;
    endfunction

    // Applies an accepted command and queues the result it must produce.
    function void note_command(logic [ils_pkg::CmdW-1:0] cmd,
                               logic [ils_pkg::PosW-1:0] pos,
                               logic [ils_pkg::DataW-1:0] val);
      list_result_t res;
      res = '0;
      res.status = ils_pkg::ST_DONE;
      case (cmd)
        ils_pkg::CMD_READ: begin
          if (pos < contents.size()) res.read_value = contents[pos];
          else res.status = ils_pkg::ST_RANGE;
        end
        ils_pkg::CMD_INS_HEAD: res.status = put_entry(0, val);
        ils_pkg::CMD_INS_TAIL: res.status = put_entry(contents.size(), val);
        ils_pkg::CMD_INS_AT:   res.status = put_entry(pos, val);
        ils_pkg::CMD_DELETE: begin
          if (pos >= contents.size()) res.status = ils_pkg::ST_RANGE;
          else contents.delete(pos);
        end
        default: ;
      endcase
      res.list_length = ils_pkg::LenW'(contents.size());
      pending.push_back(res);
    endfunction

    // Compares one result transfer with the oldest outstanding prediction.
    function void check_result(logic [ils_pkg::OutW-1:0] word);
      list_result_t exp_res;
      list_result_t got;
      got.read_value  = word[31:0];
      got.status      = word[33:32];
      got.list_length = word[44:34];
      if (pending.size() == 0) begin
        $display("%0t: result with none outstanding, got %h", $time, word);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.read_value !== exp_res.read_value) begin
        $display("%0t: read_value expected %h got %h", $time,
                 exp_res.read_value, got.read_value);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $display("%0t: status expected %0d got %0d", $time,
                 exp_res.status, got.status);
        errors++;
      end
      if (got.list_length !== exp_res.list_length) begin
        $display("%0t: list_length expected %0d got %0d", $time,
                 exp_res.list_length, got.list_length);
        errors++;
      end
      if (word[47:45] !== 3'b000) begin
        $display("%0t: padding expected 0 got %b", $time, word[47:45]);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i    = 1'b0;
  logic                     rst_ni   = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic [ils_pkg::InW-1:0]  s_tdata  = '0;
  logic                     m_tready = 1'b0;
  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [ils_pkg::OutW-1:0] m_axis_tdata;

  list_scoreboard  sb;
  int unsigned     quiet_cycles = 0;
  int unsigned     tx_calm = 0;
  int unsigned     rx_calm = 0;
  int unsigned     rx_stall = 0;

  indexed_list_store #(
    .CAPACITY(Cap)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Length of an idle stretch: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Random data word, with the sign and all-ones extremes favoured.
  function automatic logic [ils_pkg::DataW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid positions, some just past the end, a few anywhere.
  function automatic logic [ils_pkg::PosW-1:0] pick_position(
      logic [ils_pkg::CmdW-1:0] cmd);
    int lim;
    int unsigned r;
    lim = (cmd == ils_pkg::CMD_INS_AT) ? int'(sb.length()) : int'(sb.length()) - 1;
    r = $urandom_range(0, 99);
    if (r < 80 && lim >= 0) return ils_pkg::PosW'($urandom_range(0, lim));
    if (r < 93) return ils_pkg::PosW'(sb.length() + $urandom_range(0, 2));
    return ils_pkg::PosW'($urandom_range(0, 2047));
  endfunction

  // Drives one command and returns at the edge where it is transferred.
  task automatic send_cmd(logic [ils_pkg::CmdW-1:0] cmd,
                          logic [ils_pkg::PosW-1:0] pos,
                          logic [ils_pkg::DataW-1:0] val);
    int unsigned gap;
    if (tx_calm > 0) begin
      gap = 0;
      tx_calm--;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, val, pos, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, pos, val);
  endtask

  // Holds the command stream off until every result has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  // One random command; grow_w sets the share of inserts against deletes.
  task automatic random_command(int unsigned grow_w);
    int unsigned r;
    logic [ils_pkg::CmdW-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 22) cmd = ils_pkg::CMD_READ;
    else if (r < 25) cmd = ils_pkg::CmdW'($urandom_range(5, 7));
    else if (r < 25 + grow_w) cmd = ils_pkg::CmdW'($urandom_range(1, 3));
    else cmd = ils_pkg::CMD_DELETE;
    send_cmd(cmd, pick_position(cmd), rand_value());
  endtask

  // Result checking, receiver stalls and the no-progress watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) sb.check_result(m_axis_tdata);
      if ((m_axis_tvalid && m_tready) || (s_tvalid && s_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("indexed_list_store verification failed");
        $finish;
      end
      if (rx_stall > 0) begin
        m_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_tready <= 1'b1;
        if (rx_calm > 0) begin
          rx_calm--;
        end else begin
          rx_stall = idle_len();
          if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned r;
    sb = new(Cap);
    repeat (ResetLen) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases, starting from the empty list.
    send_cmd(ils_pkg::CMD_READ,     11'd0,    32'h1111_1111);
    send_cmd(ils_pkg::CMD_DELETE,   11'd0,    32'h0);
    send_cmd(ils_pkg::CMD_INS_AT,   11'd1,    32'h2222_2222);
    send_cmd(ils_pkg::CMD_INS_AT,   11'd0,    32'h8000_0000);
    send_cmd(ils_pkg::CMD_INS_HEAD, 11'd2047, 32'h7fff_ffff);
    send_cmd(ils_pkg::CMD_INS_TAIL, 11'd0,    32'hffff_ffff);
    send_cmd(ils_pkg::CMD_READ,     11'd0,    32'h0);
    send_cmd(ils_pkg::CMD_READ,     11'd1,    32'h0);
    send_cmd(ils_pkg::CMD_READ,     11'd2,    32'h0);
    send_cmd(ils_pkg::CMD_READ,     11'd3,    32'h0);
    send_cmd(ils_pkg::CMD_READ,     11'd2047, 32'hffff_ffff);
    send_cmd(ils_pkg::CMD_INS_AT,   11'd3,    32'h0);
    send_cmd(ils_pkg::CMD_INS_AT,   11'd1,    32'h5a5a_a5a5);
    send_cmd(ils_pkg::CMD_DELETE,   11'd4,    32'h0);
    send_cmd(ils_pkg::CMD_DELETE,   11'd0,    32'h0);
    send_cmd(ils_pkg::CMD_DELETE,   11'd1,    32'h0);
    send_cmd(ils_pkg::CMD_DELETE,   11'd1024, 32'h0);
    // Unused command codes must leave the list alone.
    send_cmd(ils_pkg::CmdW'(5),     11'd0,    32'hdead_beef);
    send_cmd(ils_pkg::CmdW'(6),     11'd1,    32'h0);
    send_cmd(ils_pkg::CmdW'(7),     11'd2047, 32'hffff_ffff);
    // Emptying the list by its head, then appending to the empty list.
    send_cmd(ils_pkg::CMD_DELETE,   11'd0,    32'h0);
    send_cmd(ils_pkg::CMD_DELETE,   11'd0,    32'h0);
    send_cmd(ils_pkg::CMD_INS_TAIL, 11'd5,    32'h1234_5678);
    send_cmd(ils_pkg::CMD_READ,     11'd0,    32'h0);
    wait_drained();

    // Shallow list: cheap shifts, many boundary hits.
    repeat (ShallowLen) random_command(sb.length() < 40 ? 40 : 30);
    wait_drained();

    // Grow the list, mostly by cheap tail inserts.
    while (sb.length() < GrowLen) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_cmd(ils_pkg::CMD_INS_TAIL, ils_pkg::PosW'($urandom_range(0, 2047)),
                 rand_value());
      end else if (r < 90) begin
        send_cmd(ils_pkg::CMD_INS_HEAD, ils_pkg::PosW'($urandom_range(0, 2047)),
                 rand_value());
      end else begin
        send_cmd(ils_pkg::CMD_READ, pick_position(ils_pkg::CMD_READ), rand_value());
      end
    end

    // Probes of the deep list: the longest shifts, both ends and just past them.
    send_cmd(ils_pkg::CMD_DELETE,   11'd0, 32'h0);
    send_cmd(ils_pkg::CMD_INS_HEAD, 11'd0, 32'h8000_0001);
    send_cmd(ils_pkg::CMD_READ,     11'd0, 32'h0);
    send_cmd(ils_pkg::CMD_READ,     ils_pkg::PosW'(sb.length() - 1), 32'h0);
    send_cmd(ils_pkg::CMD_READ,     ils_pkg::PosW'(sb.length()), 32'h0);
    send_cmd(ils_pkg::CMD_DELETE,   ils_pkg::PosW'(sb.length()), 32'h0);
    send_cmd(ils_pkg::CMD_INS_AT,   ils_pkg::PosW'(sb.length() + 1), 32'h0bad_0005);
    send_cmd(ils_pkg::CMD_INS_AT,   ils_pkg::PosW'(sb.length()), 32'h7fff_fffe);
    send_cmd(ils_pkg::CMD_DELETE,   ils_pkg::PosW'(sb.length() - 1), 32'h0);
    wait_drained();

    // Deep list: long shifts with random positions.
    repeat (DeepLen) random_command(37);

    // Wait for the last results, then watch for anything stray.
    wait_drained();
    repeat (SettleLen) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("indexed_list_store verification clean");
    end else begin
      $display("indexed_list_store verification failed");
    end
    $finish;
  end

endmodule
